### design/ltdht_pkg.sv
// Shared types and constants for the layer table with damage box and hit test.
// No dependencies; every other file uses this package.
`default_nettype none

package ltdht_pkg;

  // Table size and coordinate width
  localparam int MAX_LAYERS = 16;
  localparam int COORD_BITS = 16;

  // Fixed field widths
  localparam int ID_W   = 16;
  localparam int Z_W    = 16;
  localparam int SIZE_W = 15;
  localparam int OPV_W  = 16;
  localparam int OPA_W  = 8;
  localparam int DMG_W  = 17;

  localparam logic [OPA_W-1:0] OPACITY_MAX = 8'd255;

  // Derived widths: table index, fill count, right/bottom edges, box extents
  localparam int IDX_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
  localparam int SUM_W  = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W + 1) + 1;
  localparam int DIFF_W = SUM_W + 1;

  // Command codes
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_MOVE    = 3'd1,
    OP_OPACITY = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_HIT     = 3'd4
  } ltdht_op_t;

  // One command beat
  typedef struct packed {
    logic [2:0]                   opcode;
    logic [ID_W-1:0]              layer_id;
    logic signed [Z_W-1:0]        z_order;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [SIZE_W-1:0]            width;
    logic [SIZE_W-1:0]            height;
    logic signed [OPV_W-1:0]      opacity_value;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } ltdht_item_t;

  // One result beat
  typedef struct packed {
    logic                         status;
    logic                         hit_found;
    logic [ID_W-1:0]              hit_layer_id;
    logic                         damage_valid;
    logic signed [COORD_BITS-1:0] damage_x;
    logic signed [COORD_BITS-1:0] damage_y;
    logic [DMG_W-1:0]             damage_w;
    logic [DMG_W-1:0]             damage_h;
  } ltdht_result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted command
    logic scan;       // walk the table one entry
    logic merge_old;  // merge the found entry's rectangle
    logic merge_new;  // merge the moved rectangle and store the new position
    logic apply;      // add an entry or clear the damage box
    logic out_load;   // load the result register
  } ltdht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;   // index has reached the fill count
    logic id_match;   // entry at index carries the command's id
  } ltdht_stat_t;

endpackage

`default_nettype wire

### design/ltdht_if.sv
// Valid/ready channel interfaces for command and result beats.
// Depends on ltdht_pkg for the payload structs.
`default_nettype none

interface ltdht_cmd_if;
  logic                  valid;
  logic                  ready;
  ltdht_pkg::ltdht_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ltdht_rsp_if;
  logic                    valid;
  logic                    ready;
  ltdht_pkg::ltdht_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/ltdht_datapath.sv
// Datapath: command register, layer table, scan index, hit search, damage box
// and result register. Depends on ltdht_pkg; driven by ltdht_ctrl commands.
`default_nettype none

module ltdht_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  ltdht_pkg::ltdht_cmd_t    cmd,
  input  ltdht_pkg::ltdht_item_t   item,
  output ltdht_pkg::ltdht_stat_t   stat,
  output ltdht_pkg::ltdht_result_t result
);
  import ltdht_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [Z_W:0]          zbest_t;

  // Captured command
  logic [2:0]        op;
  logic [ID_W-1:0]   id;
  logic signed [Z_W-1:0] z;
  coord_t            px, py, qx, qy;
  logic [SIZE_W-1:0] w, h;
  logic [OPA_W-1:0]  opa;
  logic              fail;

  // Layer table
  logic [ID_W-1:0]       tbl_id  [MAX_LAYERS];
  logic signed [Z_W-1:0] tbl_z   [MAX_LAYERS];
  coord_t                tbl_x   [MAX_LAYERS];
  coord_t                tbl_y   [MAX_LAYERS];
  logic [SIZE_W-1:0]     tbl_w   [MAX_LAYERS];
  logic [SIZE_W-1:0]     tbl_h   [MAX_LAYERS];
  logic [OPA_W-1:0]      tbl_opa [MAX_LAYERS];
  logic [CNT_W-1:0]      count;

  // Scan state
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] sel;
  zbest_t           best_z;
  logic             best_found;
  logic [ID_W-1:0]  best_id;

  // Damage box
  coord_t box_left, box_top;
  sum_t   box_right, box_bottom;
  logic   box_pending;

  logic             is_find, is_hit, full;
  logic [OPA_W-1:0] opa_clamp;
  sum_t             ex_r, ey_b;
  logic             pt_in, z_wins;
  coord_t           mx, my;
  sum_t             mr, mb;
  diff_t            dw, dh;

  assign sel     = idx[IDX_W-1:0];
  assign is_find = (op == OP_MOVE) || (op == OP_OPACITY);
  assign is_hit  = (op == OP_HIT);
  assign full    = (count >= CNT_W'(MAX_LAYERS));

  assign stat.scan_end = (idx >= count);
  assign stat.id_match = (tbl_id[sel] == id);

  // Opacity clamp to 0..255
  always_comb begin
    if (item.opacity_value < 0) begin
      opa_clamp = '0;
    end else if (item.opacity_value > $signed({{(OPV_W-OPA_W){1'b0}}, OPACITY_MAX})) begin
      opa_clamp = OPACITY_MAX;
    end else begin
      opa_clamp = item.opacity_value[OPA_W-1:0];
    end
  end

  // Containment of the hit point in the entry at the scan index
  assign ex_r   = sum_t'(tbl_x[sel]) + sum_t'({1'b0, tbl_w[sel]});
  assign ey_b   = sum_t'(tbl_y[sel]) + sum_t'({1'b0, tbl_h[sel]});
  assign pt_in  = (qx >= tbl_x[sel]) && (sum_t'(qx) < ex_r) &&
                  (qy >= tbl_y[sel]) && (sum_t'(qy) < ey_b);
  assign z_wins = (zbest_t'(tbl_z[sel]) > best_z);

  // Rectangle to merge: found entry, or its new position on the second merge
  always_comb begin
    mx = cmd.merge_new ? px : tbl_x[sel];
    my = cmd.merge_new ? py : tbl_y[sel];
    mr = sum_t'(mx) + sum_t'({1'b0, tbl_w[sel]});
    mb = sum_t'(my) + sum_t'({1'b0, tbl_h[sel]});
  end

  // Command capture, scan and fail flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fail       <= 1'b0;
      idx        <= '0;
      best_found <= 1'b0;
    end else if (cmd.load) begin
      op         <= item.opcode;
      id         <= item.layer_id;
      z          <= item.z_order;
      px         <= item.pos_x;
      py         <= item.pos_y;
      w          <= item.width;
      h          <= item.height;
      opa        <= opa_clamp;
      qx         <= item.point_x;
      qy         <= item.point_y;
      idx        <= '0;
      best_z     <= '1;
      best_found <= 1'b0;
      best_id    <= '0;
      fail       <= ((item.opcode == OP_ADD) && full) || (item.opcode > OP_HIT);
    end else if (cmd.scan) begin
      if (stat.scan_end) begin
        if (is_find) begin
          fail <= 1'b1;
        end
      end else if (is_hit) begin
        if (pt_in && z_wins) begin
          best_z     <= zbest_t'(tbl_z[sel]);
          best_id    <= tbl_id[sel];
          best_found <= 1'b1;
        end
        idx <= idx + 1'b1;
      end else if (!stat.id_match) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (cmd.apply && (op == OP_ADD) && !full) begin
      tbl_id[count[IDX_W-1:0]]  <= id;
      tbl_z[count[IDX_W-1:0]]   <= z;
      tbl_x[count[IDX_W-1:0]]   <= px;
      tbl_y[count[IDX_W-1:0]]   <= py;
      tbl_w[count[IDX_W-1:0]]   <= w;
      tbl_h[count[IDX_W-1:0]]   <= h;
      tbl_opa[count[IDX_W-1:0]] <= OPACITY_MAX;
    end
    if (cmd.merge_old && (op == OP_OPACITY)) begin
      tbl_opa[sel] <= opa;
    end
    if (cmd.merge_new) begin
      tbl_x[sel] <= px;
      tbl_y[sel] <= py;
    end
  end

  // Fill count and damage box
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      box_pending <= 1'b0;
      box_left    <= '0;
      box_top     <= '0;
      box_right   <= '0;
      box_bottom  <= '0;
    end else begin
      if (cmd.apply && (op == OP_ADD) && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.apply && (op == OP_CLEAR)) begin
        box_pending <= 1'b0;
      end
      if (cmd.merge_old || cmd.merge_new) begin
        box_pending <= 1'b1;
        if (!box_pending || (mx < box_left))  box_left   <= mx;
        if (!box_pending || (my < box_top))   box_top    <= my;
        if (!box_pending || (mr > box_right)) box_right  <= mr;
        if (!box_pending || (mb > box_bottom)) box_bottom <= mb;
      end
    end
  end

  // Result register
  assign dw = diff_t'(box_right) - diff_t'(box_left);
  assign dh = diff_t'(box_bottom) - diff_t'(box_top);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.status       <= fail;
      result.hit_found    <= best_found;
      result.hit_layer_id <= best_id;
      result.damage_valid <= box_pending;
      result.damage_x     <= box_pending ? box_left : '0;
      result.damage_y     <= box_pending ? box_top  : '0;
      result.damage_w     <= box_pending ? dw[DMG_W-1:0] : '0;
      result.damage_h     <= box_pending ? dh[DMG_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

### design/ltdht_ctrl.sv
// Controller state machine: sequences capture, table scan, merges and result
// load. Depends on ltdht_pkg; drives ltdht_datapath through ltdht_cmd_t.
`default_nettype none

module ltdht_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [2:0]             in_opcode,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  ltdht_pkg::ltdht_stat_t stat,
  output ltdht_pkg::ltdht_cmd_t  cmd
);
  import ltdht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE_OLD,
    S_MERGE_NEW,
    S_APPLY,
    S_FINISH
  } state_t;

  state_t     state, state_next;
  logic [2:0] op;
  logic       accept, out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (in_opcode) inside
            OP_MOVE, OP_OPACITY, OP_HIT: state_next = S_SCAN;
            default:                     state_next = S_APPLY;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = S_FINISH;
        end else if ((op != OP_HIT) && stat.id_match) begin
          state_next = S_MERGE_OLD;
        end
      end
      S_MERGE_OLD: begin
        cmd.merge_old = 1'b1;
        state_next    = (op == OP_MOVE) ? S_MERGE_NEW : S_FINISH;
      end
      S_MERGE_NEW: begin
        cmd.merge_new = 1'b1;
        state_next    = S_FINISH;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, captured opcode and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op <= in_opcode;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The second merge of a move directly follows the first
  a_merge_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_new |-> $past(cmd.merge_old))
    else $error("merge_new without preceding merge_old");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // One command at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("command accepted while busy");

  // Result valid rises only from a result load
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without load");

endmodule

`default_nettype wire

### design/layer_table_damage_hit_test.sv
// Top level: layer table with damage bounding box and hit test.
// Depends on ltdht_pkg, ltdht_if, ltdht_ctrl and ltdht_datapath.
`default_nettype none

// Takes one command beat at a time on cmd_in and returns exactly one result
// beat on rsp_out, which carries the status, the hit test answer and the
// damage box as it stands after the command. Add and clear pass from capture
// through the apply step to the result load; move and set opacity scan the
// table to the entry with the matching id and merge its rectangle (set opacity)
// or its old and then its new rectangle (move), or finish when the id is absent;
// hit test scans every layer in the table (up to 16). All three are paced by
// the table scan, which reads one entry per cycle. A new command is taken as
// soon as the previous one has been written into the result register, so the
// next command can run while a result still waits on rsp_out.
module layer_table_damage_hit_test (
  input  logic        clk,
  input  logic        rst,
  ltdht_cmd_if.sink   cmd_in,
  ltdht_rsp_if.source rsp_out
);
  import ltdht_pkg::*;

  ltdht_cmd_t cmd;
  ltdht_stat_t stat;

  ltdht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_opcode (cmd_in.payload.opcode),
    .in_ready  (cmd_in.ready),
    .out_valid (rsp_out.valid),
    .out_ready (rsp_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ltdht_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (cmd_in.payload),
    .stat   (stat),
    .result (rsp_out.payload)
  );

endmodule

`default_nettype wire

### sim/layer_table_damage_hit_test_tb.sv
// Testbench for the layer table with damage box and hit test: directed and random
// command beats, each result checked against an in-bench model of the table.
// Depends on ltdht_pkg, ltdht_if and the layer_table_damage_hit_test RTL.
`default_nettype none

module layer_table_damage_hit_test_tb;
  import ltdht_pkg::*;

  // Opcodes the block does not define; each must fail and change nothing
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam int RANDOM_BEATS = 900;
  localparam int PHASE_BEATS  = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    ltdht_item_t beat;
    int          phase;
    bit          drain;    // hold this beat until every result is back
  } pending_beat_t;

  logic clk;
  logic rst;

  ltdht_cmd_if cmd_ch ();
  ltdht_rsp_if rsp_ch ();

  layer_table_damage_hit_test dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_ch),
    .rsp_out (rsp_ch)
  );

  // Idle percentages per phase: sender gaps and receiver stalls
  int send_idle_pct [3] = '{13, 70, 0};
  int recv_stall_pct[3] = '{70, 13, 0};

  pending_beat_t command_queue[$];
  ltdht_result_t results_due[$];
  int  cur_phase = 0;
  int  gen_phase = 0;
  bit  beat_taken = 1'b0;
  int  mismatches = 0;
  int  result_count = 0;
  int  cycle_count = 0;

  // Model of the layer table and the damage box
  logic [ID_W-1:0]  lyr_id     [MAX_LAYERS];
  int               lyr_z      [MAX_LAYERS];
  int               lyr_x      [MAX_LAYERS];
  int               lyr_y      [MAX_LAYERS];
  int               lyr_w      [MAX_LAYERS];
  int               lyr_h      [MAX_LAYERS];
  logic [OPA_W-1:0] lyr_opacity[MAX_LAYERS];
  int  lyr_count = 0;
  int  dmg_left = 0, dmg_top = 0, dmg_right = 0, dmg_bottom = 0;
  bit  dmg_pending = 1'b0;

  // Stimulus-side view of the table, used to aim ids and hit points
  logic [ID_W-1:0] plan_id[MAX_LAYERS];
  int plan_x[MAX_LAYERS];
  int plan_y[MAX_LAYERS];
  int plan_w[MAX_LAYERS];
  int plan_h[MAX_LAYERS];
  int plan_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Grow the damage box to cover a rectangle, or start it
  function automatic void grow_damage(int x, int y, int w, int h);
    if (!dmg_pending) begin
      dmg_left    = x;
      dmg_top     = y;
      dmg_right   = x + w;
      dmg_bottom  = y + h;
      dmg_pending = 1'b1;
    end else begin
      if (x < dmg_left) dmg_left = x;
      if (y < dmg_top) dmg_top = y;
      if (x + w > dmg_right) dmg_right = x + w;
      if (y + h > dmg_bottom) dmg_bottom = y + h;
    end
  endfunction

  // Apply one command to the table model and return the result it gives
  function automatic ltdht_result_t apply_command(ltdht_item_t c);
    ltdht_result_t r;
    int slot, best_z, qx, qy, ov;
    r = '0;
    slot = -1;
    // earliest entry with the id wins
    for (int i = lyr_count - 1; i >= 0; i--)
      if (lyr_id[i] == c.layer_id) slot = i;
    case (c.opcode)
      OP_ADD: begin
        if (lyr_count >= MAX_LAYERS) begin
          r.status = 1'b1;
        end else begin
          lyr_id[lyr_count]      = c.layer_id;
          lyr_z[lyr_count]       = $signed(c.z_order);
          lyr_x[lyr_count]       = $signed(c.pos_x);
          lyr_y[lyr_count]       = $signed(c.pos_y);
          lyr_w[lyr_count]       = c.width;
          lyr_h[lyr_count]       = c.height;
          lyr_opacity[lyr_count] = OPACITY_MAX;
          lyr_count++;
        end
      end
      OP_MOVE: begin
        if (slot < 0) begin
          r.status = 1'b1;
        end else begin
          grow_damage(lyr_x[slot], lyr_y[slot], lyr_w[slot], lyr_h[slot]);
          lyr_x[slot] = $signed(c.pos_x);
          lyr_y[slot] = $signed(c.pos_y);
          grow_damage(lyr_x[slot], lyr_y[slot], lyr_w[slot], lyr_h[slot]);
        end
      end
      OP_OPACITY: begin
        if (slot < 0) begin
          r.status = 1'b1;
        end else begin
          ov = $signed(c.opacity_value);
          lyr_opacity[slot] = (ov < 0) ? '0 :
                              (ov > int'(OPACITY_MAX)) ? OPACITY_MAX : 8'(ov);
          grow_damage(lyr_x[slot], lyr_y[slot], lyr_w[slot], lyr_h[slot]);
        end
      end
      OP_CLEAR: begin
        dmg_pending = 1'b0;
      end
      OP_HIT: begin
        // only z >= 0 can win; strict compare keeps the earliest among equals
        best_z = -1;
        qx = $signed(c.point_x);
        qy = $signed(c.point_y);
        for (int i = 0; i < lyr_count; i++)
          if (qx >= lyr_x[i] && qx < lyr_x[i] + lyr_w[i] &&
              qy >= lyr_y[i] && qy < lyr_y[i] + lyr_h[i] && lyr_z[i] > best_z) begin
            best_z         = lyr_z[i];
            r.hit_layer_id = lyr_id[i];
            r.hit_found    = 1'b1;
          end
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    if (dmg_pending) begin
      r.damage_valid = 1'b1;
      r.damage_x     = 16'(dmg_left);
      r.damage_y     = 16'(dmg_top);
      r.damage_w     = DMG_W'(dmg_right - dmg_left);
      r.damage_h     = DMG_W'(dmg_bottom - dmg_top);
    end
    return r;
  endfunction

  function automatic string show(ltdht_result_t r);
    return $sformatf("st=%0d hit=%0d id=%h dv=%0d x=%0d y=%0d w=%0d h=%0d",
                     r.status, r.hit_found, r.hit_layer_id, r.damage_valid,
                     r.damage_x, r.damage_y, r.damage_w, r.damage_h);
  endfunction

  function automatic ltdht_item_t cmd_of(logic [2:0] op, int id, int z, int x, int y,
                                         int w, int h, int ov, int qx, int qy);
    ltdht_item_t c;
    c.opcode        = op;
    c.layer_id      = 16'(id);
    c.z_order       = 16'(z);
    c.pos_x         = 16'(x);
    c.pos_y         = 16'(y);
    c.width         = 15'(w);
    c.height        = 15'(h);
    c.opacity_value = 16'(ov);
    c.point_x       = 16'(qx);
    c.point_y       = 16'(qy);
    return c;
  endfunction

  // Queue a beat and keep the stimulus-side table view in step
  function automatic void queue_cmd(ltdht_item_t c, bit drain);
    pending_beat_t p;
    int k;
    p.beat  = c;
    p.phase = gen_phase;
    p.drain = drain;
    command_queue.push_back(p);
    if (c.opcode == OP_ADD && plan_count < MAX_LAYERS) begin
      plan_id[plan_count] = c.layer_id;
      plan_x[plan_count]  = $signed(c.pos_x);
      plan_y[plan_count]  = $signed(c.pos_y);
      plan_w[plan_count]  = c.width;
      plan_h[plan_count]  = c.height;
      plan_count++;
    end else if (c.opcode == OP_MOVE) begin
      k = -1;
      for (int i = plan_count - 1; i >= 0; i--)
        if (plan_id[i] == c.layer_id) k = i;
      if (k >= 0) begin
        plan_x[k] = $signed(c.pos_x);
        plan_y[k] = $signed(c.pos_y);
      end
    end
  endfunction

  // Mostly ids already in the table, some absent ones
  function automatic logic [ID_W-1:0] pick_id();
    if (plan_count > 0 && $urandom_range(99) < 85)
      return plan_id[$urandom_range(plan_count - 1)];
    else if ($urandom_range(1))
      return 16'($urandom_range(15));
    else
      return 16'($urandom);
  endfunction

  function automatic ltdht_item_t random_cmd();
    ltdht_item_t c;
    int pick, j;
    // start from fully random fields so unused ones toggle too
    c.opcode        = OP_CLEAR;
    c.layer_id      = 16'($urandom);
    c.z_order       = 16'($urandom);
    c.pos_x         = 16'($urandom);
    c.pos_y         = 16'($urandom);
    c.width         = 15'($urandom);
    c.height        = 15'($urandom);
    c.opacity_value = 16'($urandom);
    c.point_x       = 16'($urandom);
    c.point_y       = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      c.opcode = OP_ADD;
      if ($urandom_range(9) < 8) begin
        c.layer_id = 16'($urandom_range(11));
        c.z_order  = 16'($urandom_range(7) - 2);
        c.pos_x    = 16'($urandom_range(600) - 300);
        c.pos_y    = 16'($urandom_range(600) - 300);
        c.width    = 15'($urandom_range(400));
        c.height   = 15'($urandom_range(400));
      end
    end else if (pick < 34) begin
      c.opcode   = OP_MOVE;
      c.layer_id = pick_id();
      if ($urandom_range(99) < 85) begin
        c.pos_x = 16'($urandom_range(600) - 300);
        c.pos_y = 16'($urandom_range(600) - 300);
      end
    end else if (pick < 52) begin
      c.opcode   = OP_OPACITY;
      c.layer_id = pick_id();
      if ($urandom_range(1))
        c.opacity_value = 16'($urandom_range(300) - 20);
    end else if (pick < 59) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 94) begin
      c.opcode = OP_HIT;
      if (plan_count > 0 && $urandom_range(99) < 75) begin
        // aim at a known rectangle, right/bottom edge included
        j = $urandom_range(plan_count - 1);
        c.point_x = 16'(plan_x[j] + $urandom_range(plan_w[j]));
        c.point_y = 16'(plan_y[j] + $urandom_range(plan_h[j]));
      end else if ($urandom_range(9) < 8) begin
        c.point_x = 16'($urandom_range(800) - 400);
        c.point_y = 16'($urandom_range(800) - 400);
      end
    end else begin
      c.opcode = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    return c;
  endfunction

  // Command driver: falling edge, holds a beat until it is taken
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (command_queue.size() != 0 &&
          !(command_queue[0].drain && results_due.size() != 0) &&
          $urandom_range(99) >= send_idle_pct[command_queue[0].phase]) begin
        cmd_ch.payload <= command_queue[0].beat;
        cmd_ch.valid   <= 1'b1;
        cur_phase = command_queue[0].phase;
        void'(command_queue.pop_front());
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls per phase
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end
  end

  // Monitor: check result beats, predict on accepted command beats
  always @(posedge clk) begin
    ltdht_result_t want, got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        result_count++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: no result expected, got %s", result_count, show(got));
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.hit_found !== want.hit_found ||
              got.hit_layer_id !== want.hit_layer_id ||
              got.damage_valid !== want.damage_valid ||
              got.damage_x !== want.damage_x || got.damage_y !== want.damage_y ||
              got.damage_w !== want.damage_w || got.damage_h !== want.damage_h) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %s, got %s", result_count, show(want), show(got));
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        results_due.push_back(apply_command(cmd_ch.payload));
        beat_taken = 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    rsp_ch.ready   = 1'b0;

    // Directed: empty table, unknown ids, z rules, edges, clamp, extremes
    gen_phase = 0;
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, 5, 5), 1'b0);
    queue_cmd(cmd_of(OP_MOVE,    7, 0, 4, 4, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_OPACITY, 7, 0, 0, 0, 0, 0, 9, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_ADD,     1, -1, 0, 0, 10, 10, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, 5, 5), 1'b0);
    queue_cmd(cmd_of(OP_ADD,     2, 3, 0, 0, 10, 10, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_ADD,     3, 3, 0, 0, 10, 10, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, 5, 5), 1'b0);
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, 10, 5), 1'b0);
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, 0, 9), 1'b0);
    queue_cmd(cmd_of(OP_ADD,     2, 5, 100, 100, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_MOVE,    2, 0, 20, 20, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_OPACITY, 3, 0, 0, 0, 0, 0, -5, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_OPACITY, 3, 0, 0, 0, 0, 0, 300, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_CLEAR,   0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_OPACITY, 3, 0, 0, 0, 0, 0, 128, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_ADD, 65535, 32767, -32768, -32768, 32767, 32767, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_ADD, 0, -32768, 32767, 32767, 32767, 32767, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_MOVE, 65535, 0, 32767, 32767, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, 32767, 32767), 1'b0);
    queue_cmd(cmd_of(OP_HIT,     0, 0, 0, 0, 0, 0, 0, -32768, -32768), 1'b0);
    queue_cmd(cmd_of(OP_OPACITY, 0, 0, 0, 0, 0, 0, -32768, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_SPARE_A, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_SPARE_B, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_SPARE_C, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_cmd(cmd_of(OP_CLEAR,   0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);

    // Random: three idle phases, drained once mid-phase and at each boundary
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      gen_phase = n / PHASE_BEATS;
      queue_cmd(random_cmd(), (n == PHASE_BEATS / 2) || (n % PHASE_BEATS == 0 && n != 0));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (command_queue.size() != 0 || cmd_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/ltdht_pkg.sv
design/ltdht_if.sv
design/ltdht_datapath.sv
design/ltdht_ctrl.sv
design/layer_table_damage_hit_test.sv
sim/layer_table_damage_hit_test_tb.sv
